/* design/urbp_pkg.sv */
// ----------------------------------------------------------------------------
// urbp_pkg: shared types and constants of the UART ring buffer pair
// Ring sizing, event codes, controller states, the command and status
// bundles between controller and datapath, and the ring pointer helper.
// ----------------------------------------------------------------------------
package urbp_pkg;

	localparam int RING_DEPTH   = 256;
	localparam int PTR_W        = $clog2(RING_DEPTH);
	localparam int FILL_W       = PTR_W + 1;
	localparam int BYTE_W       = 8;
	localparam int CNT_W        = 8;
	localparam int RX_COUNT_MAX = 255;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [FILL_W-1:0] fill_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [1:0] {
		CMD_PUSH      = 2'd0,
		CMD_TX_DONE   = 2'd1,
		CMD_RX_ARRIVE = 2'd2,
		CMD_HOST_READ = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept;       // take the beat at the input, update pointers
		logic load_direct;  // load the output register from this beat's logic
		logic load_mem;     // load the output register from the pending beat
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic needs_mem;    // the offered beat returns a byte from a ring store
	} dp_status_t;

	// Advance a ring pointer, wrapping at the ring depth.
	function automatic ptr_t ptr_next(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(RING_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

/* design/uart_ring_buffer_pair.sv */
// ----------------------------------------------------------------------------
// uart_ring_buffer_pair: buffered UART host side with transmit and receive rings
// Top level joining the sequencing controller and the ring datapath.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat (in_valid, in_stall, command, data) carries one event: a host
// push of a transmit byte, a transmitter-done tick, an arriving receive byte,
// or a host read. Every event produces exactly one output beat (out_valid,
// out_stall) with the line write, push status, read result, receive count and
// transmitter busy flag as they stand after the event.
// Pushes, arrivals, and ticks or reads that find their ring empty load the
// output register straight from the accepted beat. A tick that sends a
// queued byte and a read that returns a byte load it only after the
// registered ring store read; while that read is in flight the input is
// stalled. The block takes one beat per cycle while out_stall is low, but
// a beat that reads a ring store holds off the next beat until it loads.
// The output register frees the input side: a new beat is taken while the
// previous result is being drained. When the receiver holds out_stall, the
// result stays put and in_stall rises until it is taken.
// Reset clears all pointers and the busy flag, so both rings start empty;
// the ring stores themselves are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module uart_ring_buffer_pair (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic [7:0] data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       line_write_valid,
	output logic [7:0] line_write_data,
	output logic       push_accepted,
	output logic       read_valid,
	output logic [7:0] read_data,
	output logic [7:0] rx_count,
	output logic       tx_busy
);

	urbp_pkg::ctrl_cmd_t  ctrl;
	urbp_pkg::dp_status_t status;

	// The controller owns the handshakes and the output valid flag.
	urbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.ctrl      (ctrl)
	);

	// The datapath owns both rings and the result register.
	urbp_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.status           (status),
		.command          (command),
		.data             (data),
		.line_write_valid (line_write_valid),
		.line_write_data  (line_write_data),
		.push_accepted    (push_accepted),
		.read_valid       (read_valid),
		.read_data        (read_data),
		.rx_count         (rx_count),
		.tx_busy          (tx_busy)
	);

	// A beat that needs a store read must hold off the next beat.
	a_lookup_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && status.needs_mem) |=> in_stall)
		else $error("input not stalled during ring store read");

	// Handing a byte to the line always leaves the transmitter busy.
	a_send_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && line_write_valid) |-> tx_busy)
		else $error("byte sent while transmitter reported idle");

	// One event cannot both send a byte and return a received byte.
	a_single_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(line_write_valid && read_valid))
		else $error("line write and host read in one result");

	// The output register loads only when it is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !(ctrl.load_direct || ctrl.load_mem))
		else $error("stalled result overwritten");

endmodule

/* design/urbp_ctrl.sv */
// ----------------------------------------------------------------------------
// urbp_ctrl: sequencing controller
// Decides when a beat is taken and when the output register loads. A beat
// that reads a ring store waits in the lookup state for the registered read.
// ----------------------------------------------------------------------------
module urbp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	input  urbp_pkg::dp_status_t   status,
	output urbp_pkg::ctrl_cmd_t    ctrl
);

	urbp_pkg::state_t state_q, state_d;
	logic out_valid_q, out_valid_d;
	logic out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= urbp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// The output register is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d          = state_q;
		in_stall         = 1'b1;
		ctrl.accept      = 1'b0;
		ctrl.load_direct = 1'b0;
		ctrl.load_mem    = 1'b0;
		unique case (state_q)
			urbp_pkg::ST_IDLE: begin
				in_stall = !out_free;
				if (in_valid && out_free) begin
					ctrl.accept = 1'b1;
					if (status.needs_mem) begin
						state_d = urbp_pkg::ST_LOOKUP;
					end else begin
						ctrl.load_direct = 1'b1;
					end
				end
			end
			urbp_pkg::ST_LOOKUP: begin
				if (out_free) begin
					ctrl.load_mem = 1'b1;
					state_d       = urbp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = urbp_pkg::ST_IDLE;
			end
		endcase

		if (ctrl.load_direct || ctrl.load_mem) begin
			out_valid_d = 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* design/urbp_datapath.sv */
// ----------------------------------------------------------------------------
// urbp_datapath: ring stores, pointers and result register
// Holds both ring FIFOs with their pointers and the transmitter busy flag,
// works out each event's effect and result, and keeps the output register.
// ----------------------------------------------------------------------------
module urbp_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  urbp_pkg::ctrl_cmd_t    ctrl,
	output urbp_pkg::dp_status_t   status,
	input  logic [1:0]             command,
	input  logic [7:0]             data,
	output logic                   line_write_valid,
	output logic [7:0]             line_write_data,
	output logic                   push_accepted,
	output logic                   read_valid,
	output logic [7:0]             read_data,
	output logic [7:0]             rx_count,
	output logic                   tx_busy
);

	urbp_pkg::byte_t tx_store [urbp_pkg::RING_DEPTH];
	urbp_pkg::byte_t rx_store [urbp_pkg::RING_DEPTH];

	urbp_pkg::ptr_t tx_rp_q, tx_wp_q, rx_rp_q, rx_wp_q;
	urbp_pkg::ptr_t tx_rp_d, tx_wp_d, rx_rp_d, rx_wp_d;
	logic           tx_active_q, tx_active_d;

	urbp_pkg::byte_t tx_rd_q, rx_rd_q;

	logic            tx_we, rx_we;
	logic            lw_valid, accepted, rd_valid, needs_mem;
	urbp_pkg::byte_t lw_data;
	urbp_pkg::fill_t fill;
	urbp_pkg::cnt_t  cnt;
	urbp_pkg::cmd_t  cmd;

	logic           pend_lw_valid_q, pend_accepted_q, pend_rd_valid_q, pend_busy_q;
	urbp_pkg::cnt_t pend_cnt_q;

	logic            out_lw_valid_q, out_accepted_q, out_rd_valid_q, out_busy_q;
	urbp_pkg::byte_t out_lw_data_q, out_rd_data_q;
	urbp_pkg::cnt_t  out_cnt_q;

	assign cmd = urbp_pkg::cmd_t'(command);

	always_comb begin
		tx_rp_d     = tx_rp_q;
		tx_wp_d     = tx_wp_q;
		rx_rp_d     = rx_rp_q;
		rx_wp_d     = rx_wp_q;
		tx_active_d = tx_active_q;
		tx_we       = 1'b0;
		rx_we       = 1'b0;
		lw_valid    = 1'b0;
		lw_data     = '0;
		accepted    = 1'b0;
		rd_valid    = 1'b0;
		needs_mem   = 1'b0;
		unique case (cmd)
			urbp_pkg::CMD_PUSH: begin
				if (!(tx_active_q && urbp_pkg::ptr_next(tx_wp_q) == tx_rp_q)) begin
					tx_we    = 1'b1;
					tx_wp_d  = urbp_pkg::ptr_next(tx_wp_q);
					accepted = 1'b1;
					// An idle transmitter has an empty queue, so the byte just
					// queued is the one sent straight away.
					if (!tx_active_q && tx_rp_q != tx_wp_d) begin
						lw_valid    = 1'b1;
						lw_data     = data;
						tx_rp_d     = urbp_pkg::ptr_next(tx_rp_q);
						tx_active_d = 1'b1;
					end
				end
			end
			urbp_pkg::CMD_TX_DONE: begin
				if (tx_rp_q != tx_wp_q) begin
					lw_valid  = 1'b1;
					needs_mem = 1'b1;
					tx_rp_d   = urbp_pkg::ptr_next(tx_rp_q);
				end else begin
					tx_active_d = 1'b0;
				end
			end
			urbp_pkg::CMD_RX_ARRIVE: begin
				rx_we = 1'b1;
				if (urbp_pkg::ptr_next(rx_wp_q) != rx_rp_q) begin
					rx_wp_d = urbp_pkg::ptr_next(rx_wp_q);
				end
			end
			urbp_pkg::CMD_HOST_READ: begin
				if (rx_rp_q != rx_wp_q) begin
					rd_valid  = 1'b1;
					needs_mem = 1'b1;
					rx_rp_d   = urbp_pkg::ptr_next(rx_rp_q);
				end
			end
			default: begin
			end
		endcase

		fill = {1'b0, rx_wp_d} - {1'b0, rx_rp_d};
		if (rx_wp_d < rx_rp_d) begin
			fill = fill + urbp_pkg::FILL_W'(urbp_pkg::RING_DEPTH);
		end
		if (32'(fill) > 32'(urbp_pkg::RX_COUNT_MAX)) begin
			cnt = urbp_pkg::CNT_W'(urbp_pkg::RX_COUNT_MAX);
		end else begin
			cnt = urbp_pkg::CNT_W'(fill);
		end
	end

	assign status.needs_mem = needs_mem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_rp_q     <= '0;
			tx_wp_q     <= '0;
			rx_rp_q     <= '0;
			rx_wp_q     <= '0;
			tx_active_q <= 1'b0;
		end else if (ctrl.accept) begin
			tx_rp_q     <= tx_rp_d;
			tx_wp_q     <= tx_wp_d;
			rx_rp_q     <= rx_rp_d;
			rx_wp_q     <= rx_wp_d;
			tx_active_q <= tx_active_d;
		end
	end

	// Ring stores: at most one write per beat, and a registered read of both per beat.
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			if (tx_we) begin
				tx_store[tx_wp_q] <= data;
			end
			if (rx_we) begin
				rx_store[rx_wp_q] <= data;
			end
			tx_rd_q <= tx_store[tx_rp_q];
			rx_rd_q <= rx_store[rx_rp_q];
		end
	end

	// Result fields of a beat that waits for its store read.
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			pend_lw_valid_q <= lw_valid;
			pend_accepted_q <= accepted;
			pend_rd_valid_q <= rd_valid;
			pend_busy_q     <= tx_active_d;
			pend_cnt_q      <= cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_direct) begin
			out_lw_valid_q <= lw_valid;
			out_lw_data_q  <= lw_data;
			out_accepted_q <= accepted;
			out_rd_valid_q <= 1'b0;
			out_rd_data_q  <= '0;
			out_cnt_q      <= cnt;
			out_busy_q     <= tx_active_d;
		end else if (ctrl.load_mem) begin
			out_lw_valid_q <= pend_lw_valid_q;
			out_lw_data_q  <= pend_lw_valid_q ? tx_rd_q : '0;
			out_accepted_q <= pend_accepted_q;
			out_rd_valid_q <= pend_rd_valid_q;
			out_rd_data_q  <= pend_rd_valid_q ? rx_rd_q : '0;
			out_cnt_q      <= pend_cnt_q;
			out_busy_q     <= pend_busy_q;
		end
	end

	assign line_write_valid = out_lw_valid_q;
	assign line_write_data  = out_lw_data_q;
	assign push_accepted    = out_accepted_q;
	assign read_valid       = out_rd_valid_q;
	assign read_data        = out_rd_data_q;
	assign rx_count         = out_cnt_q;
	assign tx_busy          = out_busy_q;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for uart_ring_buffer_pair
// Events are sent one beat at a time with random gaps. A model of both rings
// and the transmitter busy flag predicts each status beat. The results are
// compared field by field as they leave the block under random back-pressure.
// ----------------------------------------------------------------------------
module tb;

	// One status beat as the block reports it after an event.
	typedef struct packed {
		logic            lw_valid;
		urbp_pkg::byte_t lw_data;
		logic            accepted;
		logic            rd_valid;
		urbp_pkg::byte_t rd_data;
		urbp_pkg::cnt_t  rx_cnt;
		logic            busy;
	} uart_status_t;

	// Clock and block connections. Every input starts at a known value and
	// reset is held from time zero.
	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [1:0] command   = 2'd0;
	logic [7:0] data      = 8'd0;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic       line_write_valid;
	logic [7:0] line_write_data;
	logic       push_accepted;
	logic       read_valid;
	logic [7:0] read_data;
	logic [7:0] rx_count;
	logic       tx_busy;

	// Shadow copy of the rings, their pointers and the busy flag.
	urbp_pkg::byte_t tx_mem [urbp_pkg::RING_DEPTH];
	urbp_pkg::byte_t rx_mem [urbp_pkg::RING_DEPTH];
	urbp_pkg::ptr_t  tx_rd = '0;
	urbp_pkg::ptr_t  tx_wr = '0;
	urbp_pkg::ptr_t  rx_rd = '0;
	urbp_pkg::ptr_t  rx_wr = '0;
	logic            tx_on = 1'b0;

	// Status beats predicted but not yet seen at the output.
	uart_status_t status_q [$];

	// While set, neither side inserts gaps or stalls.
	bit quiet = 1'b0;

	int n_errors    = 0;
	int n_checked   = 0;
	int n_rejected  = 0;
	int n_overwrite = 0;
	int n_sent      = 0;
	int n_events [4] = '{0, 0, 0, 0};

	uart_ring_buffer_pair u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.data             (data),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.line_write_valid (line_write_valid),
		.line_write_data  (line_write_data),
		.push_accepted    (push_accepted),
		.read_valid       (read_valid),
		.read_data        (read_data),
		.rx_count         (rx_count),
		.tx_busy          (tx_busy)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Pointers wrap at the ring depth.
	function automatic urbp_pkg::ptr_t ring_step(urbp_pkg::ptr_t p);
		return (p == urbp_pkg::ptr_t'(urbp_pkg::RING_DEPTH - 1)) ? '0 :
		       urbp_pkg::ptr_t'(p + 1'b1);
	endfunction

	// Applies one event to the shadow state and returns the status beat
	// that the block must report for it.
	function automatic uart_status_t predict_event(urbp_pkg::cmd_t c, urbp_pkg::byte_t d);
		uart_status_t   s;
		urbp_pkg::ptr_t nxt;
		int             fill;
		s = '0;
		case (c)
			urbp_pkg::CMD_PUSH: begin
				nxt = ring_step(tx_wr);
				// A push into a full ring is refused only while the line is
				// busy; an idle transmitter always has room.
				if (tx_on && nxt == tx_rd) begin
					n_rejected++;
				end else begin
					tx_mem[tx_wr] = d;
					tx_wr = nxt;
					s.accepted = 1'b1;
					// An idle transmitter takes the byte straight away.
					if (!tx_on && tx_rd != tx_wr) begin
						s.lw_valid = 1'b1;
						s.lw_data  = tx_mem[tx_rd];
						tx_rd = ring_step(tx_rd);
						tx_on = 1'b1;
					end
				end
			end
			urbp_pkg::CMD_TX_DONE: begin
				if (tx_rd != tx_wr) begin
					s.lw_valid = 1'b1;
					s.lw_data  = tx_mem[tx_rd];
					tx_rd = ring_step(tx_rd);
				end else begin
					tx_on = 1'b0;
				end
			end
			urbp_pkg::CMD_RX_ARRIVE: begin
				// The write always lands; the pointer only moves when the ring is not
				// already full, so on a full ring the byte lands in the spare slot and is lost.
				rx_mem[rx_wr] = d;
				nxt = ring_step(rx_wr);
				if (nxt != rx_rd) begin
					rx_wr = nxt;
				end else begin
					n_overwrite++;
				end
			end
			default: begin
				if (rx_rd != rx_wr) begin
					s.rd_valid = 1'b1;
					s.rd_data  = rx_mem[rx_rd];
					rx_rd = ring_step(rx_rd);
				end
			end
		endcase
		fill = (rx_wr >= rx_rd) ? int'(rx_wr) - int'(rx_rd)
		                        : int'(rx_wr) + urbp_pkg::RING_DEPTH - int'(rx_rd);
		s.rx_cnt = (fill > urbp_pkg::RX_COUNT_MAX) ?
		           urbp_pkg::cnt_t'(urbp_pkg::RX_COUNT_MAX) : urbp_pkg::cnt_t'(fill);
		s.busy   = tx_on;
		return s;
	endfunction

	task automatic report_error(string msg);
		$display("tb: mismatch at %0t: %s", $realtime, msg);
		n_errors++;
	endtask

	// Four-state compare, so an unknown output bit counts as a mismatch.
	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			report_error($sformatf("result %0d %s got %0h want %0h",
			                       n_checked, name, got, want));
		end
	endtask

	// Sends one event beat. A random gap may come first; once the beat is
	// presented it is held until the block takes it. in_valid is left high
	// on return so that back-to-back beats never drop it within one step.
	task automatic send_beat(urbp_pkg::cmd_t c, urbp_pkg::byte_t d);
		if (!quiet) begin
			while ($urandom_range(99) < 13) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		command  <= c;
		data     <= d;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		status_q.push_back(predict_event(c, d));
		n_events[c]++;
		n_sent++;
	endtask

	// Receiver side: random stalls, then a field-by-field check of every
	// beat that leaves the block against the oldest prediction.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < 13);
		end
	end

	always @(posedge clk) begin
		uart_status_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (status_q.size() == 0) begin
				report_error("status beat with no event waiting for it");
			end else begin
				want = status_q.pop_front();
				check_field("line_write_valid", 32'(line_write_valid), 32'(want.lw_valid));
				check_field("line_write_data", 32'(line_write_data), 32'(want.lw_data));
				check_field("push_accepted", 32'(push_accepted), 32'(want.accepted));
				check_field("read_valid", 32'(read_valid), 32'(want.rd_valid));
				check_field("read_data", 32'(read_data), 32'(want.rd_data));
				check_field("rx_count", 32'(rx_count), 32'(want.rx_cnt));
				check_field("tx_busy", 32'(tx_busy), 32'(want.busy));
			end
			n_checked++;
		end
	end

	// Extremes of the data field, each command, and the idle-line cases:
	// a tick and a read against empty rings, a push straight onto an idle
	// line, a push queued behind a busy one, and the tick that goes idle.
	task automatic test_directed();
		send_beat(urbp_pkg::CMD_TX_DONE, 8'h00);
		send_beat(urbp_pkg::CMD_HOST_READ, 8'hFF);
		send_beat(urbp_pkg::CMD_PUSH, 8'h00);
		send_beat(urbp_pkg::CMD_PUSH, 8'hFF);
		send_beat(urbp_pkg::CMD_PUSH, 8'hA5);
		send_beat(urbp_pkg::CMD_PUSH, 8'h5A);
		send_beat(urbp_pkg::CMD_TX_DONE, 8'hFF);
		send_beat(urbp_pkg::CMD_TX_DONE, 8'h00);
		send_beat(urbp_pkg::CMD_TX_DONE, 8'h00);
		send_beat(urbp_pkg::CMD_TX_DONE, 8'h00);
		send_beat(urbp_pkg::CMD_TX_DONE, 8'h00);
		send_beat(urbp_pkg::CMD_RX_ARRIVE, 8'h00);
		send_beat(urbp_pkg::CMD_RX_ARRIVE, 8'hFF);
		send_beat(urbp_pkg::CMD_RX_ARRIVE, 8'h5A);
		send_beat(urbp_pkg::CMD_RX_ARRIVE, 8'hA5);
		send_beat(urbp_pkg::CMD_HOST_READ, 8'h00);
		send_beat(urbp_pkg::CMD_PUSH, 8'h81);
		send_beat(urbp_pkg::CMD_HOST_READ, 8'h00);
		send_beat(urbp_pkg::CMD_HOST_READ, 8'h00);
		send_beat(urbp_pkg::CMD_HOST_READ, 8'h00);
		send_beat(urbp_pkg::CMD_HOST_READ, 8'h00);
		send_beat(urbp_pkg::CMD_TX_DONE, 8'h00);
		send_beat(urbp_pkg::CMD_PUSH, 8'h7E);
		send_beat(urbp_pkg::CMD_TX_DONE, 8'h00);
	endtask

	// Fills the transmit ring behind a busy line until pushes bounce, then
	// drains it tick by tick until the line falls idle.
	task automatic test_tx_ring_full();
		while (tx_on) begin
			send_beat(urbp_pkg::CMD_TX_DONE, urbp_pkg::byte_t'($urandom_range(255)));
		end
		send_beat(urbp_pkg::CMD_PUSH, urbp_pkg::byte_t'($urandom_range(255)));
		while (ring_step(tx_wr) != tx_rd) begin
			send_beat(urbp_pkg::CMD_PUSH, urbp_pkg::byte_t'($urandom_range(255)));
		end
		repeat (3) send_beat(urbp_pkg::CMD_PUSH, urbp_pkg::byte_t'($urandom_range(255)));
		while (tx_on) begin
			send_beat(urbp_pkg::CMD_TX_DONE, urbp_pkg::byte_t'($urandom_range(255)));
		end
	endtask

	// Fills the receive ring, keeps bytes arriving so the spare slot is
	// overwritten, then reads everything back and once more past empty.
	task automatic test_rx_ring_full();
		while (rx_rd != rx_wr) begin
			send_beat(urbp_pkg::CMD_HOST_READ, urbp_pkg::byte_t'($urandom_range(255)));
		end
		while (ring_step(rx_wr) != rx_rd) begin
			send_beat(urbp_pkg::CMD_RX_ARRIVE, urbp_pkg::byte_t'($urandom_range(255)));
		end
		repeat (4) send_beat(urbp_pkg::CMD_RX_ARRIVE, urbp_pkg::byte_t'($urandom_range(255)));
		while (rx_rd != rx_wr) begin
			send_beat(urbp_pkg::CMD_HOST_READ, urbp_pkg::byte_t'($urandom_range(255)));
		end
		send_beat(urbp_pkg::CMD_HOST_READ, urbp_pkg::byte_t'($urandom_range(255)));
	endtask

	// Random mix of all four events. The weights swing between filling and
	// draining every few dozen beats so that both rings move across their
	// whole range; a stretch in the middle runs with no gaps or stalls.
	task automatic test_random_mix(int count);
		bit             filling;
		int             pick;
		urbp_pkg::cmd_t c;
		filling = 1'b1;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				filling = $urandom_range(1);
			end
			quiet = (i >= 200 && i < 400);
			pick = $urandom_range(99);
			if (filling) begin
				c = (pick < 35) ? urbp_pkg::CMD_PUSH : (pick < 50) ? urbp_pkg::CMD_TX_DONE :
				    (pick < 85) ? urbp_pkg::CMD_RX_ARRIVE : urbp_pkg::CMD_HOST_READ;
			end else begin
				c = (pick < 15) ? urbp_pkg::CMD_PUSH : (pick < 50) ? urbp_pkg::CMD_TX_DONE :
				    (pick < 65) ? urbp_pkg::CMD_RX_ARRIVE : urbp_pkg::CMD_HOST_READ;
			end
			send_beat(c, urbp_pkg::byte_t'($urandom_range(255)));
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_tx_ring_full();
		test_rx_ring_full();
		test_random_mix(520);

		in_valid <= 1'b0;
		while (status_q.size() != 0) begin
			@(posedge clk);
		end
		// Let a stray extra beat show itself before closing.
		repeat (8) @(posedge clk);

		$display("tb: %0d events (push %0d, tick %0d, arrive %0d, read %0d), %0d results checked",
		         n_sent, n_events[urbp_pkg::CMD_PUSH], n_events[urbp_pkg::CMD_TX_DONE],
		         n_events[urbp_pkg::CMD_RX_ARRIVE], n_events[urbp_pkg::CMD_HOST_READ],
		         n_checked);
		$display("tb: %0d pushes refused on a full ring, %0d arrivals overwrote a full ring",
		         n_rejected, n_overwrite);
		if (n_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
